// ===== src/mpq_pkg.sv =====
`default_nettype none
package mpq_pkg;
  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned LevelsDef = 5;

  localparam int unsigned ModeW = 2;
  localparam int unsigned LevelW = 3;
  localparam int unsigned PidW = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SliceW = 5;
  localparam int unsigned CountW = 7;

  localparam logic [ModeW-1:0] ModePush = 2'd0;
  localparam logic [ModeW-1:0] ModePop = 2'd1;
  localparam logic [ModeW-1:0] ModeDelete = 2'd2;
  localparam logic [ModeW-1:0] ModeNop = 2'd3;

  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StBadLevel = 3'd1;
  localparam logic [StatusW-1:0] StFull = 3'd2;
  localparam logic [StatusW-1:0] StEmpty = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;
endpackage
`default_nettype wire

// ===== src/multilevel_process_queues_core.sv =====
// Multilevel process queues: one FIFO of 6-bit process ids per priority level.
// Command channel: a word is taken on a rising edge with start high and
// busy low; it carries mode_i (push, pop, delete), level_i and process_id_i.
// Result channel: done_o is high for exactly one cycle with status_o,
// popped_id_o, slice_ticks_o and queue_count_o. The receiver cannot stall.
// Steps from the accepting edge to the result:
//   push, bad level, unused mode, or any error found from the count: no steps
//   pop: one memory read of the queue head
//   delete: a scan that reads all n entries of the queue; a hit adds a
//     pass that moves each entry behind the match at position pos down one
//     place to close the gap, with no move when the match is the tail entry.
// Each queue is a ring in one shared memory with one read and one write
// port; the scan and the gap closing move one entry per cycle over that
// port pair, which sets the delete time. busy is high until the result
// is presented; a new word may be taken in the cycle done_o is high.
// Reset clears the counts and head pointers; the entry memory needs no
// clearing since only entries below the count are ever read.
`default_nettype none
module multilevel_process_queues_core #(
  parameter int unsigned QUEUE_DEPTH = mpq_pkg::QueueDepthDef,
  parameter int unsigned LEVELS = mpq_pkg::LevelsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [mpq_pkg::ModeW-1:0]    mode_i,
  input  wire logic [mpq_pkg::LevelW-1:0]   level_i,
  input  wire logic [mpq_pkg::PidW-1:0]     process_id_i,
  output logic                              done_o,
  output logic [mpq_pkg::StatusW-1:0]       status_o,
  output logic [mpq_pkg::PidW-1:0]          popped_id_o,
  output logic [mpq_pkg::SliceW-1:0]        slice_ticks_o,
  output logic [mpq_pkg::CountW-1:0]        queue_count_o
);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned AW = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int unsigned PW = mpq_pkg::PidW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  // ring position of logical entry k
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return IW'(s);
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [LW-1:0] lv, input logic [IW-1:0] p);
    return AW'(AW'(lv) * AW'(QUEUE_DEPTH) + AW'(p));
  endfunction

  logic [PW-1:0] mem [LEVELS*QUEUE_DEPTH];
  logic [PW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [PW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_q [LEVELS];
  logic [CW-1:0] cnt_d [LEVELS];
  logic [IW-1:0] head_q [LEVELS];
  logic [IW-1:0] head_d [LEVELS];
  logic [LW-1:0] lv_q, lv_d;
  logic [PW-1:0] pid_q, pid_d;
  logic [CW-1:0] k_q, k_d;       // next entry to read
  logic          rv_q, rv_d;     // read data valid next cycle
  logic [CW-1:0] rk_q, rk_d;     // entry index of read data
  logic          hit_q, hit_d;
  logic [CW-1:0] pos_q, pos_d;

  logic                          done_d;
  logic [mpq_pkg::StatusW-1:0]   st_d;
  logic [PW-1:0]                 pop_d;
  logic [mpq_pkg::SliceW-1:0]    sl_d;
  logic [mpq_pkg::CountW-1:0]    qc_d;

  logic [LW-1:0] lvi;
  logic [CW-1:0] n_i, n_q;
  assign lvi = LW'(level_i);
  assign n_i = cnt_q[lvi];
  assign n_q = cnt_q[lv_q];
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    head_d = head_q;
    lv_d = lv_q;
    pid_d = pid_q;
    k_d = k_q;
    rv_d = 1'b0;
    rk_d = rk_q;
    hit_d = hit_q;
    pos_d = pos_q;
    we = 1'b0;
    re = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = pid_q;
    done_d = 1'b0;
    st_d = mpq_pkg::StOk;
    pop_d = '0;
    sl_d = '0;
    qc_d = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          lv_d = lvi;
          pid_d = process_id_i;
          if (int'(level_i) >= int'(LEVELS)) begin
            done_d = 1'b1;
            st_d = mpq_pkg::StBadLevel;
          end else begin
            qc_d = mpq_pkg::CountW'(n_i);
            case (mode_i)
              mpq_pkg::ModePush: begin
                done_d = 1'b1;
                if (n_i >= CW'(QUEUE_DEPTH)) begin
                  st_d = mpq_pkg::StFull;
                end else begin
                  we = 1'b1;
                  waddr = mem_addr(lvi, ring_pos(head_q[lvi], n_i));
                  wdata = process_id_i;
                  cnt_d[lvi] = n_i + CW'(1);
                  qc_d = mpq_pkg::CountW'(n_i + CW'(1));
                end
              end
              mpq_pkg::ModePop: begin
                if (n_i == '0) begin
                  done_d = 1'b1;
                  st_d = mpq_pkg::StEmpty;
                end else begin
                  re = 1'b1;
                  raddr = mem_addr(lvi, head_q[lvi]);
                  state_d = S_POP;
                end
              end
              mpq_pkg::ModeDelete: begin
                if (n_i == '0) begin
                  done_d = 1'b1;
                  st_d = mpq_pkg::StNotFound;
                end else begin
                  k_d = '0;
                  hit_d = 1'b0;
                  state_d = S_SCAN;
                end
              end
              default: begin
                done_d = 1'b1;
              end
            endcase
          end
        end
      end
      S_POP: begin
        done_d = 1'b1;
        pop_d = rdata_q;
        sl_d = mpq_pkg::SliceW'(32'd1 << lv_q);
        head_d[lv_q] = ring_pos(head_q[lv_q], CW'(1));
        cnt_d[lv_q] = n_q - CW'(1);
        qc_d = mpq_pkg::CountW'(n_q - CW'(1));
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (rv_q && rdata_q == pid_q) begin
          hit_d = 1'b1;
          pos_d = rk_q;
        end
        if (k_q < n_q) begin
          re = 1'b1;
          raddr = mem_addr(lv_q, ring_pos(head_q[lv_q], k_q));
          rv_d = 1'b1;
          rk_d = k_q;
          k_d = k_q + CW'(1);
        end else if (!rv_q) begin
          if (!hit_q) begin
            done_d = 1'b1;
            st_d = mpq_pkg::StNotFound;
            qc_d = mpq_pkg::CountW'(n_q);
            state_d = S_IDLE;
          end else begin
            k_d = pos_q + CW'(1);
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // entry rk moves down to rk-1
        if (rv_q) begin
          we = 1'b1;
          waddr = mem_addr(lv_q, ring_pos(head_q[lv_q], rk_q - CW'(1)));
          wdata = rdata_q;
        end
        if (k_q < n_q) begin
          re = 1'b1;
          raddr = mem_addr(lv_q, ring_pos(head_q[lv_q], k_q));
          rv_d = 1'b1;
          rk_d = k_q;
          k_d = k_q + CW'(1);
        end else if (!rv_q) begin
          done_d = 1'b1;
          cnt_d[lv_q] = n_q - CW'(1);
          qc_d = mpq_pkg::CountW'(n_q - CW'(1));
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q <= 1'b0;
      hit_q <= 1'b0;
      done_o <= 1'b0;
      for (int i = 0; i < int'(LEVELS); i++) begin
        cnt_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      rv_q <= rv_d;
      hit_q <= hit_d;
      done_o <= done_d;
      cnt_q <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lv_q <= lv_d;
    pid_q <= pid_d;
    k_q <= k_d;
    rk_q <= rk_d;
    pos_q <= pos_d;
    status_o <= st_d;
    popped_id_o <= pop_d;
    slice_ticks_o <= sl_d;
    queue_count_o <= qc_d;
  end
endmodule
`default_nettype wire

// ===== src/mpq_checker.sv =====
`default_nettype none
module mpq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         done_o,
  input wire logic [mpq_pkg::StatusW-1:0]  status_o,
  input wire logic [mpq_pkg::PidW-1:0]     popped_id_o,
  input wire logic [mpq_pkg::SliceW-1:0]   slice_ticks_o,
  input wire logic [mpq_pkg::CountW-1:0]   queue_count_o
);
  // every accepted word either answers next cycle or holds busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy) else $error("word lost");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= mpq_pkg::StNotFound) else $error("bad status");
  a_errzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != mpq_pkg::StOk |-> popped_id_o == '0 && slice_ticks_o == '0)
    else $error("error word carries pop data");
  a_badlv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == mpq_pkg::StBadLevel |-> queue_count_o == '0)
    else $error("bad level with count");
endmodule

bind multilevel_process_queues_core mpq_checker u_mpq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .status_o(status_o), .popped_id_o(popped_id_o), .slice_ticks_o(slice_ticks_o),
  .queue_count_o(queue_count_o)
);
`default_nettype wire
